FILE: rtl/core/skrt_pkg.sv
`timescale 1ns / 1ps
package skrt_pkg;

  localparam int TableDepthDef = 16;
  localparam int NameBytesDef  = 25;
  localparam int NameBitsMax   = 200;

  localparam logic [2:0] FuncInsert = 3'd0;
  localparam logic [2:0] FuncSearch = 3'd1;
  localparam logic [2:0] FuncUpdate = 3'd2;
  localparam logic [2:0] FuncList   = 3'd3;
  localparam logic [2:0] FuncErase  = 3'd4;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNotFound = 3'd1,
    StExists   = 3'd2,
    StFull     = 3'd3,
    StEmpty    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_UPD,
    S_ERS_RD,
    S_ERS_WR,
    S_LIST_RD,
    S_LIST_OUT,
    S_EMIT
  } state_t;

  typedef struct packed {
    status_t                 status;
    logic signed [31:0]      key;
    logic [NameBitsMax-1:0]  name;
    logic signed [31:0]      quantity;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } emit_t;

endpackage

FILE: rtl/core/skrt_in_if.sv
`timescale 1ns / 1ps
interface skrt_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] part_key;
  logic [63:0]        name_bytes_0_7;
  logic [63:0]        name_bytes_8_15;
  logic [63:0]        name_bytes_16_23;
  logic [7:0]         name_byte_24;
  logic signed [31:0] amount;

  modport source (
    output valid, func, part_key, name_bytes_0_7, name_bytes_8_15, name_bytes_16_23,
    output name_byte_24, amount,
    input  ready
  );
  modport sink (
    input  valid, func, part_key, name_bytes_0_7, name_bytes_8_15, name_bytes_16_23,
    input  name_byte_24, amount,
    output ready
  );
endinterface

FILE: rtl/core/skrt_out_if.sv
`timescale 1ns / 1ps
interface skrt_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] out_key;
  logic [63:0]        out_name_0_7;
  logic [63:0]        out_name_8_15;
  logic [63:0]        out_name_16_23;
  logic [7:0]         out_name_24;
  logic signed [31:0] out_quantity;
  logic               last_result;

  modport source (
    output valid, status, out_key, out_name_0_7, out_name_8_15, out_name_16_23,
    output out_name_24, out_quantity, last_result,
    input  ready
  );
  modport sink (
    input  valid, status, out_key, out_name_0_7, out_name_8_15, out_name_16_23,
    input  out_name_24, out_quantity, last_result,
    output ready
  );
endinterface

FILE: rtl/core/skrt_ram.sv
`timescale 1ns / 1ps
module skrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/skrt_outreg.sv
`timescale 1ns / 1ps
module skrt_outreg (
  input  logic                clk,
  input  logic                rst_n,
  input  skrt_pkg::emit_t     emit,
  output logic                free,
  skrt_out_if.source          out_ch
);

  logic              valid_r;
  skrt_pkg::result_t data_r;

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (emit.push) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.push) begin
      data_r <= emit.res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.status         = data_r.status;
  assign out_ch.out_key        = data_r.key;
  assign out_ch.out_name_0_7   = data_r.name[63:0];
  assign out_ch.out_name_8_15  = data_r.name[127:64];
  assign out_ch.out_name_16_23 = data_r.name[191:128];
  assign out_ch.out_name_24    = data_r.name[199:192];
  assign out_ch.out_quantity   = data_r.quantity;
  assign out_ch.last_result    = data_r.last;

endmodule

FILE: rtl/core/skrt_ctrl.sv
`timescale 1ns / 1ps
module skrt_ctrl #(
  parameter int TABLE_DEPTH = skrt_pkg::TableDepthDef,
  parameter int NAME_BYTES  = skrt_pkg::NameBytesDef,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int RW = 8 * NAME_BYTES + 64
) (
  input  logic            clk,
  input  logic            rst_n,
  skrt_in_if.sink         in_ch,
  output skrt_pkg::emit_t emit,
  input  logic            emit_free,
  output logic            ram_we,
  output logic [AW-1:0]   ram_waddr,
  output logic [RW-1:0]   ram_wdata,
  output logic            ram_re,
  output logic [AW-1:0]   ram_raddr,
  input  logic [RW-1:0]   ram_rdata
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = 8 * NAME_BYTES;

  // record layout: quantity, key, name (low bytes first)
  function automatic skrt_pkg::result_t mk_res(
    input skrt_pkg::status_t st,
    input logic [31:0]       key,
    input logic [NW-1:0]     name,
    input logic [31:0]       qty,
    input logic              last
  );
    skrt_pkg::result_t r;
    r          = '0;
    r.status   = st;
    r.key      = key;
    r.name[NW-1:0] = name;
    r.quantity = qty;
    r.last     = last;
    return r;
  endfunction

  skrt_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     mv_r, mv_nxt;
  logic [2:0]        func_r, func_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [NW-1:0]     name_r, name_nxt;
  logic signed [31:0] amt_r, amt_nxt;
  logic              hit_r, hit_nxt;
  logic [RW-1:0]     rec_r, rec_nxt;
  skrt_pkg::result_t res_r, res_nxt;

  logic                            in_acc;
  logic [skrt_pkg::NameBitsMax-1:0] name_full;
  logic signed [31:0]              rd_key;
  logic                            rd_less;
  logic [CW-1:0]                   idx_inc, mv_inc, mv_dec;
  logic                            full;
  logic signed [32:0]              sum;
  logic [31:0]                     sat_qty;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign name_full = {in_ch.name_byte_24, in_ch.name_bytes_16_23,
                      in_ch.name_bytes_8_15, in_ch.name_bytes_0_7};
  assign rd_key    = ram_rdata[NW+31:NW];
  assign rd_less   = rd_key < key_r;
  assign idx_inc   = idx_r + CW'(1);
  assign mv_inc    = mv_r + CW'(1);
  assign mv_dec    = mv_r - CW'(1);
  assign full      = count_r == CW'(TABLE_DEPTH);

  // saturating add on the stored quantity
  assign sum = {rec_r[RW-1], rec_r[RW-1:NW+32]} + {amt_r[31], amt_r};
  always_comb begin
    if (sum[32] != sum[31]) begin
      sat_qty = sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      sat_qty = sum[31:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      skrt_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_ch.func == skrt_pkg::FuncList) begin
            state_nxt = (count_r == '0) ? skrt_pkg::S_EMIT : skrt_pkg::S_LIST_RD;
          end else if (in_ch.func inside {skrt_pkg::FuncInsert, skrt_pkg::FuncSearch,
                                          skrt_pkg::FuncUpdate, skrt_pkg::FuncErase}) begin
            state_nxt = skrt_pkg::S_SCAN_RD;
          end
        end
      end
      skrt_pkg::S_SCAN_RD: begin
        state_nxt = (idx_r == count_r) ? skrt_pkg::S_DECIDE : skrt_pkg::S_SCAN_CMP;
      end
      skrt_pkg::S_SCAN_CMP: begin
        state_nxt = rd_less ? skrt_pkg::S_SCAN_RD : skrt_pkg::S_DECIDE;
      end
      skrt_pkg::S_DECIDE: begin
        case (func_r)
          skrt_pkg::FuncInsert: begin
            state_nxt = (full || hit_r) ? skrt_pkg::S_EMIT : skrt_pkg::S_INS_RD;
          end
          skrt_pkg::FuncUpdate: state_nxt = hit_r ? skrt_pkg::S_UPD : skrt_pkg::S_EMIT;
          skrt_pkg::FuncErase:  state_nxt = hit_r ? skrt_pkg::S_ERS_RD : skrt_pkg::S_EMIT;
          default:              state_nxt = skrt_pkg::S_EMIT;
        endcase
      end
      skrt_pkg::S_INS_RD: begin
        state_nxt = (mv_r == idx_r) ? skrt_pkg::S_INS_PUT : skrt_pkg::S_INS_WR;
      end
      skrt_pkg::S_INS_WR:  state_nxt = skrt_pkg::S_INS_RD;
      skrt_pkg::S_INS_PUT: state_nxt = skrt_pkg::S_EMIT;
      skrt_pkg::S_UPD:     state_nxt = skrt_pkg::S_EMIT;
      skrt_pkg::S_ERS_RD: begin
        state_nxt = (mv_inc >= count_r) ? skrt_pkg::S_EMIT : skrt_pkg::S_ERS_WR;
      end
      skrt_pkg::S_ERS_WR:  state_nxt = skrt_pkg::S_ERS_RD;
      skrt_pkg::S_LIST_RD: state_nxt = skrt_pkg::S_LIST_OUT;
      skrt_pkg::S_LIST_OUT: begin
        if (emit_free) begin
          state_nxt = (idx_inc == count_r) ? skrt_pkg::S_IDLE : skrt_pkg::S_LIST_RD;
        end
      end
      skrt_pkg::S_EMIT: begin
        if (emit_free) begin
          state_nxt = skrt_pkg::S_IDLE;
        end
      end
      default: state_nxt = skrt_pkg::S_IDLE;
    endcase
  end

  // memory port, handshake and result push
  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_r[AW-1:0];
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = idx_r[AW-1:0];
    emit.push   = 1'b0;
    emit.res    = res_r;
    case (state_r)
      skrt_pkg::S_IDLE: in_ch.ready = 1'b1;
      skrt_pkg::S_SCAN_RD: begin
        ram_re = idx_r != count_r;
      end
      skrt_pkg::S_INS_RD: begin
        ram_re    = mv_r != idx_r;
        ram_raddr = mv_dec[AW-1:0];
      end
      skrt_pkg::S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = mv_r[AW-1:0];
      end
      skrt_pkg::S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = {amt_r, key_r, name_r};
      end
      skrt_pkg::S_UPD: begin
        ram_we    = 1'b1;
        ram_wdata = {sat_qty, rec_r[NW+31:0]};
      end
      skrt_pkg::S_ERS_RD: begin
        ram_re    = mv_inc < count_r;
        ram_raddr = mv_inc[AW-1:0];
      end
      skrt_pkg::S_ERS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = mv_r[AW-1:0];
      end
      skrt_pkg::S_LIST_RD: ram_re = 1'b1;
      skrt_pkg::S_LIST_OUT: begin
        emit.push = emit_free;
        emit.res  = mk_res(skrt_pkg::StOk, ram_rdata[NW+31:NW], ram_rdata[NW-1:0],
                           ram_rdata[RW-1:NW+32], idx_inc == count_r);
      end
      skrt_pkg::S_EMIT: emit.push = emit_free;
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    mv_nxt    = mv_r;
    func_nxt  = func_r;
    key_nxt   = key_r;
    name_nxt  = name_r;
    amt_nxt   = amt_r;
    hit_nxt   = hit_r;
    rec_nxt   = rec_r;
    res_nxt   = res_r;
    case (state_r)
      skrt_pkg::S_IDLE: begin
        if (in_acc) begin
          func_nxt = in_ch.func;
          key_nxt  = in_ch.part_key;
          name_nxt = name_full[NW-1:0];
          amt_nxt  = in_ch.amount;
          idx_nxt  = '0;
          hit_nxt  = 1'b0;
          res_nxt  = mk_res(skrt_pkg::StEmpty, '0, '0, '0, 1'b1);
        end
      end
      skrt_pkg::S_SCAN_CMP: begin
        if (rd_less) begin
          idx_nxt = idx_inc;
        end else begin
          hit_nxt = rd_key == key_r;
          rec_nxt = ram_rdata;
        end
      end
      skrt_pkg::S_DECIDE: begin
        mv_nxt  = hit_r ? idx_r : count_r;
        res_nxt = mk_res(skrt_pkg::StNotFound, key_r, '0, '0, 1'b1);
        case (func_r)
          skrt_pkg::FuncInsert: begin
            if (full) begin
              res_nxt.status = skrt_pkg::StFull;
            end else if (hit_r) begin
              res_nxt.status = skrt_pkg::StExists;
            end
          end
          default: begin
            if (hit_r) begin
              res_nxt = mk_res(skrt_pkg::StOk, rec_r[NW+31:NW], rec_r[NW-1:0],
                               rec_r[RW-1:NW+32], 1'b1);
            end
          end
        endcase
      end
      skrt_pkg::S_INS_WR: mv_nxt = mv_dec;
      skrt_pkg::S_INS_PUT: begin
        count_nxt = count_r + CW'(1);
        res_nxt   = mk_res(skrt_pkg::StOk, key_r, name_r, amt_r, 1'b1);
      end
      skrt_pkg::S_UPD: res_nxt.quantity = sat_qty;
      skrt_pkg::S_ERS_RD: begin
        if (mv_inc >= count_r) begin
          count_nxt = count_r - CW'(1);
        end
      end
      skrt_pkg::S_ERS_WR: mv_nxt = mv_inc;
      skrt_pkg::S_LIST_OUT: begin
        if (emit_free) begin
          idx_nxt = idx_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skrt_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    mv_r   <= mv_nxt;
    func_r <= func_nxt;
    key_r  <= key_nxt;
    name_r <= name_nxt;
    amt_r  <= amt_nxt;
    hit_r  <= hit_nxt;
    rec_r  <= rec_nxt;
    res_r  <= res_nxt;
  end

endmodule

FILE: rtl/core/sorted_keyed_record_table.sv
`timescale 1ns / 1ps
// one request at a time; search and update first scan the records in key order up to the key
// insert and erase then move each later record by one place to open or close the gap
// list reads a record, then emits it once the output register is free, then reads the next
// the next request is taken as soon as the last result sits in the output register
// reset is synchronous and empties the table; record memory is not cleared, no clearing pass
module sorted_keyed_record_table #(
  parameter int TABLE_DEPTH = skrt_pkg::TableDepthDef,
  parameter int NAME_BYTES  = skrt_pkg::NameBytesDef
) (
  input  logic       clk,
  input  logic       rst_n,
  skrt_in_if.sink    in_ch,
  skrt_out_if.source out_ch
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RW = 8 * NAME_BYTES + 64;

  skrt_pkg::emit_t emit;
  logic            emit_free;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [RW-1:0]   ram_wdata, ram_rdata;

  skrt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NAME_BYTES  (NAME_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .emit      (emit),
    .emit_free (emit_free),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  skrt_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  skrt_outreg u_outreg (
    .clk    (clk),
    .rst_n  (rst_n),
    .emit   (emit),
    .free   (emit_free),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  // a result is never pushed over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit.push |-> emit_free)
    else $error("result pushed into a full output register");

  // the walk never reads and writes the memory in the same cycle
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("record memory read and write collide");

  // no table change while a new request can be taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !ram_we && !emit.push)
    else $error("table activity while idle");
`endif

endmodule
